@@ rtl/dccc_pkg.sv @@
// Shared types, constants and calendar helper functions for the day count calendar converter.
package dccc_pkg;

  localparam int unsigned DCCC_QUEUE_DEPTH = 2;

  localparam logic [13:0] FIRST_YEAR         = 14'd1970;
  localparam logic [13:0] LAST_YEAR          = 14'd9999;
  localparam logic [21:0] LAST_DAY_NUMBER    = 22'd2932896;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd477;
  localparam logic [2:0]  EPOCH_WEEKDAY      = 3'd4;

  // Reciprocal of 100 scaled by 2^19; exact quotient for any 14-bit year.
  localparam logic [12:0] RECIP_100 = 13'd5243;
  // Reciprocal of the mean Gregorian year (365.2425 days) scaled by 2^30.
  localparam logic [21:0] RECIP_YEAR = 22'd2939805;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_MAY = 4'd5;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_JUL = 4'd7;
  localparam logic [3:0] MONTH_AUG = 4'd8;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_OCT = 4'd10;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    CMD_INVALID,
    CMD_TO_DAYS,
    CMD_TO_DATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [21:0] t;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        leap;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EST,
    ST_YMUL,
    ST_YCMP,
    ST_MONTH,
    ST_FIN
  } back_state_t;

  function automatic logic [4:0] month_length(logic [3:0] month, logic leap);
    logic [4:0] len;
    case (month)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of the given month.
  function automatic logic [8:0] days_before_month(logic [3:0] month, logic leap);
    logic [8:0] base;
    case (month)
      MONTH_JAN: base = 9'd0;
      MONTH_FEB: base = 9'd31;
      MONTH_MAR: base = 9'd59;
      MONTH_APR: base = 9'd90;
      MONTH_MAY: base = 9'd120;
      MONTH_JUN: base = 9'd151;
      MONTH_JUL: base = 9'd181;
      MONTH_AUG: base = 9'd212;
      MONTH_SEP: base = 9'd243;
      MONTH_OCT: base = 9'd273;
      MONTH_NOV: base = 9'd304;
      MONTH_DEC: base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap && (month >= MONTH_MAR)};
  endfunction

  // Days from the epoch to January 1 of year x + 1, given the registered
  // products (x + 1 - 1970) * 365 and x * RECIP_100.
  function automatic logic [22:0] days_before_year(logic [22:0] p365, logic [25:0] p100,
                                                   logic [13:0] x);
    logic [6:0]  q100;
    logic [11:0] leaps;
    q100  = p100[25:19];
    leaps = 12'(x[13:2]) - 12'(q100) + 12'(q100[6:2]);
    return p365 + 23'(leaps) - 23'(LEAPS_BEFORE_EPOCH);
  endfunction

  // Remainder by 7 using 8 = 1 (mod 7): fold the octal digits together.
  function automatic logic [2:0] mod7(logic [22:0] v);
    logic [23:0] w;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [3:0]  s3;
    w  = {1'b0, v};
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 6'(w[3*i +: 3]);
    end
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    s3 = 4'(s2[2:0]) + 4'(s2[3]);
    return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
  endfunction

endpackage

@@ rtl/dccc_front.sv @@
// Front end: accepts items, range-checks them and builds one command for the back end.
module dccc_front (
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               mode,
  input  logic [4:0]         day,
  input  logic [3:0]         month,
  input  logic [13:0]        year,
  input  logic [21:0]        day_number,
  input  logic signed [22:0] offset,
  input  logic               full,
  output logic               push,
  output dccc_pkg::cmd_t     cmd
);
  import dccc_pkg::*;

  logic [26:0] y_prod;
  logic        div100;
  logic        div400;
  logic        leap;
  logic        date_ok;
  logic [23:0] sum;
  logic        sum_ok;

  assign cmd_ready = !full;
  assign push      = cmd_valid && !full;

  always_comb begin
    // With y = 100q + r the low 19 bits of y * 5243 are 12q + 5243r,
    // which stays below 5243 exactly when r is zero.
    y_prod  = 27'(year) * 27'(RECIP_100);
    div100  = y_prod[18:0] < 19'(RECIP_100);
    div400  = div100 && (y_prod[20:19] == 2'b00);
    leap    = ((year[1:0] == 2'b00) && !div100) || div400;
    date_ok = (year >= FIRST_YEAR) && (year <= LAST_YEAR) &&
              (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
              (day != 5'd0) && (day <= month_length(month, leap));

    sum    = {2'b00, day_number} + {offset[22], offset};
    sum_ok = (day_number <= LAST_DAY_NUMBER) && !sum[23] &&
             (sum[22:0] <= 23'(LAST_DAY_NUMBER));

    cmd.t     = sum[21:0];
    cmd.day   = day;
    cmd.month = month;
    cmd.year  = year;
    cmd.leap  = leap;
    if (mode) begin
      cmd.kind = sum_ok ? CMD_TO_DATE : CMD_INVALID;
    end else begin
      cmd.kind = date_ok ? CMD_TO_DAYS : CMD_INVALID;
    end
  end

endmodule

@@ rtl/dccc_queue.sv @@
// Small command queue between the front end and the back end.
module dccc_queue #(
  parameter int unsigned DEPTH = dccc_pkg::DCCC_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dccc_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output dccc_pkg::cmd_t pop_data,
  output logic           empty
);
  import dccc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10: count <= count + CNT_W'(1);
        2'b01: count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from an empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("push without pop did not grow the queue");

endmodule

@@ rtl/dccc_back.sv @@
// Back end: sequencer that resolves the year, picks the month and holds the result register.
module dccc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  dccc_pkg::cmd_t head,
  output logic           pop,
  output logic           res_valid,
  input  logic           res_ready,
  output logic           valid_res,
  output logic [21:0]    result_day_number,
  output logic [4:0]     result_day,
  output logic [3:0]     result_month,
  output logic [13:0]    result_year,
  output logic [2:0]     weekday
);
  import dccc_pkg::*;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  cmd_t        cur_next;
  logic [13:0] y;
  logic [13:0] y_next;
  logic [22:0] p365;
  logic [22:0] p365_next;
  logic [25:0] p100_lo;
  logic [25:0] p100_lo_next;
  logic [25:0] p100_hi;
  logic [25:0] p100_hi_next;
  logic [8:0]  rem;
  logic [8:0]  rem_next;
  logic [43:0] est_prod;
  logic [22:0] dby_lo;
  logic [22:0] dby_hi;
  logic [22:0] t_ext;
  logic [3:0]  m_sel;
  logic [8:0]  m_base;
  logic [2:0]  wd;
  logic        load_res;

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    y_next       = y;
    p365_next    = p365;
    p100_lo_next = p100_lo;
    p100_hi_next = p100_hi;
    rem_next     = rem;
    pop          = 1'b0;
    load_res     = 1'b0;

    t_ext    = {1'b0, cur.t};
    est_prod = 44'(cur.t) * 44'(RECIP_YEAR);
    // Start of year y and of year y + 1.
    dby_lo   = days_before_year(p365, p100_lo, y - 14'd1);
    dby_hi   = days_before_year(p365 + 23'(DAYS_PER_YEAR), p100_hi, y);
    wd       = mod7(t_ext + 23'(EPOCH_WEEKDAY));

    // Last month whose first day is not past the day of the year.
    m_sel = MONTH_JAN;
    for (int m = 2; m <= 12; m++) begin
      if (rem >= days_before_month(4'(m), cur.leap)) begin
        m_sel = 4'(m);
      end
    end
    m_base = days_before_month(m_sel, cur.leap);

    case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          cur_next = head;
          y_next   = head.year;
          case (head.kind)
            CMD_TO_DAYS: state_next = ST_YMUL;
            CMD_TO_DATE: state_next = ST_EST;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_EST: begin
        y_next     = FIRST_YEAR + est_prod[43:30];
        state_next = ST_YMUL;
      end
      ST_YMUL: begin
        p365_next    = 23'(y - FIRST_YEAR) * 23'(DAYS_PER_YEAR);
        p100_lo_next = 26'(y - 14'd1) * 26'(RECIP_100);
        p100_hi_next = 26'(y) * 26'(RECIP_100);
        state_next   = ST_YCMP;
      end
      ST_YCMP: begin
        if (cur.kind == CMD_TO_DAYS) begin
          cur_next.t = 22'(dby_lo + 23'(days_before_month(cur.month, cur.leap)) +
                           23'(cur.day) - 23'd1);
          state_next = ST_FIN;
        end else if (dby_lo > t_ext) begin
          y_next     = y - 14'd1;
          state_next = ST_YMUL;
        end else if (dby_hi <= t_ext) begin
          y_next     = y + 14'd1;
          state_next = ST_YMUL;
        end else begin
          rem_next      = 9'(t_ext - dby_lo);
          cur_next.leap = (dby_hi - dby_lo) != 23'(DAYS_PER_YEAR);
          state_next    = ST_MONTH;
        end
      end
      ST_MONTH: begin
        cur_next.month = m_sel;
        cur_next.day   = 5'(rem - m_base + 9'd1);
        cur_next.year  = y;
        state_next     = ST_FIN;
      end
      ST_FIN: begin
        if (!res_valid || res_ready) begin
          load_res   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    y       <= y_next;
    p365    <= p365_next;
    p100_lo <= p100_lo_next;
    p100_hi <= p100_hi_next;
    rem     <= rem_next;
    if (load_res) begin
      if (cur.kind == CMD_INVALID) begin
        valid_res         <= 1'b0;
        result_day_number <= '0;
        result_day        <= '0;
        result_month      <= '0;
        result_year       <= '0;
        weekday           <= '0;
      end else begin
        valid_res         <= 1'b1;
        result_day_number <= cur.t;
        result_day        <= cur.day;
        result_month      <= cur.month;
        result_year       <= cur.year;
        weekday           <= wd;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk)
    rst |=> state == ST_IDLE && !res_valid)
    else $error("back end not idle after reset");

  a_rem_in_year: assert property (@(posedge clk) disable iff (rst)
    state == ST_MONTH |-> rem <= 9'd365)
    else $error("day of year out of range");

  a_year_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FIN && cur.kind != CMD_INVALID |->
      cur.year >= FIRST_YEAR && cur.year <= LAST_YEAR)
    else $error("resolved year out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !valid_res |-> result_day_number == '0 && weekday == '0)
    else $error("invalid result carries nonzero fields");

  a_valid_month: assert property (@(posedge clk) disable iff (rst)
    res_valid && valid_res |-> result_month != '0 && result_month <= MONTH_DEC)
    else $error("valid result with month out of range");

endmodule

@@ rtl/day_count_calendar_converter_core.sv @@
// Top level of the day count calendar converter: front end, command queue and back end.
// An invalid item goes straight to ST_FIN; a date to day number item via ST_YMUL, ST_YCMP,
// ST_FIN; a day number to date item via ST_EST, ST_YMUL, ST_YCMP (both again per year
// correction, at most one), ST_MONTH, ST_FIN. The back end works on one item at a time; the
// queue takes up to QUEUE_DEPTH more items meanwhile. Reset (rst, synchronous, active high)
// empties the queue, idles the sequencer and drops res_valid; no other clearing is needed.
module day_count_calendar_converter_core #(
  // Queue depth, 2 to 16 entries.
  parameter int unsigned QUEUE_DEPTH = dccc_pkg::DCCC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  logic               mode,
  input  logic [4:0]         day,
  input  logic [3:0]         month,
  input  logic [13:0]        year,
  input  logic [21:0]        day_number,
  input  logic signed [22:0] offset,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               valid_res,
  output logic [21:0]        result_day_number,
  output logic [4:0]         result_day,
  output logic [3:0]         result_month,
  output logic [13:0]        result_year,
  output logic [2:0]         weekday
);
  import dccc_pkg::*;

  // The front end does all the checks that need no iteration: it validates a
  // civil date (including February 29 by a reciprocal divide of the year) and
  // adds the signed offset to the day number, range checking the sum. Each
  // item becomes one command tagged invalid, date to days, or days to date.
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  dccc_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .mode       (mode),
    .day        (day),
    .month      (month),
    .year       (year),
    .day_number (day_number),
    .offset     (offset),
    .full       (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  // The queue decouples acceptance from the iterative back end, so a new item
  // is taken while an earlier one is still being worked on or waits at the
  // output register, as long as the queue is not full.
  dccc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (head_cmd),
    .empty     (empty)
  );

  // The back end estimates the year from the day number with a reciprocal of
  // the mean year length, then corrects it one year at a time by comparing
  // against the start days of that year and the next. The months are found by
  // comparing the day of the year against all month starts at once. For a
  // civil date the same year start logic gives the day number directly. The
  // weekday comes from the day number modulo 7. The result sits in an output
  // register until it is taken.
  dccc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .empty             (empty),
    .head              (head_cmd),
    .pop               (pop),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .valid_res         (valid_res),
    .result_day_number (result_day_number),
    .result_day        (result_day),
    .result_month      (result_month),
    .result_year       (result_year),
    .weekday           (weekday)
  );

endmodule

@@ bench/tb_day_count_calendar_converter_core.sv @@
// Self-checking testbench for the day count calendar converter core.
module tb_day_count_calendar_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dccc_pkg::*;

  // The mode bit selects the direction of the conversion.
  localparam logic MODE_TO_DAYS = 1'b0;
  localparam logic MODE_TO_DATE = 1'b1;

  // Cycles without any item moving on either channel before the run is declared hung.
  // The longest legal quiet stretch is the deliberate receiver hold-off below.
  localparam int unsigned HANG_LIMIT = 4000;
  // Length of the one long receiver hold-off, and the result count that triggers it.
  localparam int unsigned LONG_STALL = 400;
  localparam int unsigned STALL_AT_RESULT = 120;
  // Cycles to keep watching the result channel after the last expected result.
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 625;

  // One input item as the sender presents it. The flag asks the sender to hold the
  // item back until every earlier result has come out.
  typedef struct packed {
    logic               drain_first;
    logic               mode;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [13:0]        year;
    logic [21:0]        day_number;
    logic signed [22:0] offset;
  } conv_item_t;

  // One result item, field for field as on the output ports.
  typedef struct packed {
    logic        ok;
    logic [21:0] dn;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [2:0]  wd;
  } calendar_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  logic               mode = MODE_TO_DAYS;
  logic [4:0]         day = '0;
  logic [3:0]         month = '0;
  logic [13:0]        year = '0;
  logic [21:0]        day_number = '0;
  logic signed [22:0] offset = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  logic               valid_res;
  logic [21:0]        result_day_number;
  logic [4:0]         result_day;
  logic [3:0]         result_month;
  logic [13:0]        result_year;
  logic [2:0]         weekday;

  conv_item_t       pending_items[$];
  calendar_result_t expected_results[$];
  conv_item_t       item_on_wire;
  conv_item_t       next_item;
  calendar_result_t want;
  logic             offer_item;

  int unsigned total_items;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          long_stall_done;

  day_count_calendar_converter_core u_top (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .mode              (mode),
    .day               (day),
    .month             (month),
    .year              (year),
    .day_number        (day_number),
    .offset            (offset),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .valid_res         (valid_res),
    .result_day_number (result_day_number),
    .result_day        (result_day),
    .result_month      (result_month),
    .result_year       (result_year),
    .weekday           (weekday)
  );

  // 2 ns clock period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic for the expected results, in plain integers.
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == MONTH_FEB) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
      return 30;
    end
    return 31;
  endfunction

  // Number of leap years from year 1 through year y.
  function automatic int unsigned leap_days_through(int unsigned y);
    return y / 4 - y / 100 + y / 400;
  endfunction

  // Days from the epoch to January 1 of year y; years up to the epoch give zero.
  function automatic int unsigned days_to_year(int unsigned y);
    if (y <= FIRST_YEAR) begin
      return 0;
    end
    return (y - FIRST_YEAR) * 365 + leap_days_through(y - 1) - leap_days_through(FIRST_YEAR - 1);
  endfunction

  // Expected result for one item. Any out-of-range input gives an all-zero result.
  function automatic calendar_result_t predict_conversion(conv_item_t it);
    calendar_result_t r;
    int unsigned      y;
    int unsigned      m;
    int unsigned      d;
    int unsigned      t;
    int unsigned      rem;
    int               sum;
    r = '0;
    if (it.mode == MODE_TO_DAYS) begin
      y = 32'(it.year);
      m = 32'(it.month);
      d = 32'(it.day);
      if (y < FIRST_YEAR || y > LAST_YEAR || m == 0 || m > 12) begin
        return r;
      end
      if (d == 0 || d > days_in_month(m, y)) begin
        return r;
      end
      t = days_to_year(y);
      for (int unsigned k = 1; k < m; k++) begin
        t += days_in_month(k, y);
      end
      t += d - 1;
    end else begin
      // A day number beyond the last date poisons the item whatever the offset.
      if (it.day_number > LAST_DAY_NUMBER) begin
        return r;
      end
      sum = int'(it.day_number) + int'($signed(it.offset));
      if (sum < 0 || sum > int'(LAST_DAY_NUMBER)) begin
        return r;
      end
      t = unsigned'(sum);
      // Start from an estimate that is never too low, then settle on the year.
      y = FIRST_YEAR + t / 365;
      while (days_to_year(y + 1) <= t) begin
        y++;
      end
      while (days_to_year(y) > t) begin
        y--;
      end
      rem = t - days_to_year(y);
      m = 1;
      while (m < 12 && rem >= days_in_month(m, y)) begin
        rem -= days_in_month(m, y);
        m++;
      end
      d = rem + 1;
    end
    r.ok = 1'b1;
    r.dn = 22'(t);
    r.d  = 5'(d);
    r.m  = 4'(m);
    r.y  = 14'(y);
    r.wd = 3'((32'(EPOCH_WEEKDAY) + t) % 7);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction.
  // ---------------------------------------------------------------------------

  // Every field but drain_first random; the fields that the mode ignores stay that way, so their
  // bits toggle throughout the run.
  function automatic conv_item_t random_fields();
    conv_item_t it;
    it.drain_first = 1'b0;
    it.mode        = 1'($urandom_range(1, 0));
    it.day         = 5'($urandom_range(31, 0));
    it.month       = 4'($urandom_range(15, 0));
    it.year        = 14'($urandom_range(16383, 0));
    it.day_number  = 22'($urandom_range(4194303, 0));
    it.offset      = 23'($urandom_range(8388607, 0));
    return it;
  endfunction

  task automatic queue_date(input int unsigned d, input int unsigned m, input int unsigned y);
    conv_item_t it;
    it       = random_fields();
    it.mode  = MODE_TO_DAYS;
    it.day   = 5'(d);
    it.month = 4'(m);
    it.year  = 14'(y);
    pending_items.push_back(it);
  endtask

  task automatic queue_shift(input int unsigned dn, input int off);
    conv_item_t it;
    it            = random_fields();
    it.mode       = MODE_TO_DATE;
    it.day_number = 22'(dn);
    it.offset     = 23'(off);
    pending_items.push_back(it);
  endtask

  // Leap-rule years show up far more often than a flat draw would give them.
  function automatic int unsigned pick_year();
    case ($urandom_range(3, 0))
      0: return $urandom_range(99, 20) * 100;
      1: return $urandom_range(2499, 493) * 4;
      default: return $urandom_range(LAST_YEAR, FIRST_YEAR);
    endcase
  endfunction

  // Random item: mostly well-formed dates and in-range shifts with random content,
  // the rest near-misses and raw noise.
  function automatic conv_item_t random_item();
    conv_item_t  it;
    int unsigned y;
    int unsigned m;
    int unsigned len;
    int          target;
    it = random_fields();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        // Valid date, with the first and last day of the month favored.
        y   = pick_year();
        m   = $urandom_range(12, 1);
        len = days_in_month(m, y);
        it.mode  = MODE_TO_DAYS;
        it.year  = 14'(y);
        it.month = 4'(m);
        case ($urandom_range(3, 0))
          0: it.day = 5'd1;
          1: it.day = 5'(len);
          default: it.day = 5'($urandom_range(len, 1));
        endcase
      end
      4: begin
        // One day past the end of the month, or the 29th of February in any year.
        y = pick_year();
        m = $urandom_range(12, 1);
        it.mode  = MODE_TO_DAYS;
        it.year  = 14'(y);
        it.month = 4'(m);
        it.day   = 5'(days_in_month(m, y) + 1);
        if ($urandom_range(1, 0) == 0) begin
          it.month = MONTH_FEB;
          it.day   = 5'd29;
        end
      end
      5, 6, 7, 8: begin
        // Shift: to anywhere in range, near a new year, or one day either way, which can leave the range.
        it.mode = MODE_TO_DATE;
        case ($urandom_range(2, 0))
          0: target = int'($urandom_range(LAST_DAY_NUMBER, 0));
          1: target = int'(days_to_year(pick_year() + $urandom_range(1, 0)))
                      + int'($urandom_range(2, 0)) - 1;
          default: target = -1;
        endcase
        if (target < 0) begin
          it.day_number = 22'($urandom_range(LAST_DAY_NUMBER, 0));
          it.offset     = ($urandom_range(1, 0) != 0) ? 23'sd1 : -23'sd1;
        end else begin
          if (target > int'(LAST_DAY_NUMBER)) begin
            target = int'(LAST_DAY_NUMBER);
          end
          it.day_number = 22'($urandom_range(LAST_DAY_NUMBER, 0));
          it.offset     = 23'(target - int'(it.day_number));
        end
      end
      default: begin
        // Raw noise in either mode, already in it.
      end
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle profile: sender idles 33 percent and receiver 77 percent for the first
  // third, then the other way round, then neither idles.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_percent(int unsigned done, bit receiver);
    if (done < total_items / 3) begin
      return receiver ? 77 : 33;
    end
    if (done < 2 * total_items / 3) begin
      return receiver ? 33 : 77;
    end
    return 0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents items from the pending queue and records the expected result
  // at the edge where each item is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        expected_results.push_back(predict_conversion(item_on_wire));
        items_accepted++;
      end
      // A held item stays on the wire untouched until it is taken.
      if (!cmd_valid || cmd_ready) begin
        offer_item = 1'b0;
        if (pending_items.size() != 0 &&
            $urandom_range(99, 0) >= idle_percent(items_accepted, 1'b0)) begin
          // A marked item waits until the block has emptied completely.
          if (!pending_items[0].drain_first || expected_results.size() == 0) begin
            offer_item = 1'b1;
          end
        end
        if (offer_item) begin
          next_item    = pending_items.pop_front();
          item_on_wire = next_item;
          mode         <= next_item.mode;
          day          <= next_item.day;
          month        <= next_item.month;
          year         <= next_item.year;
          day_number   <= next_item.day_number;
          offset       <= next_item.offset;
        end
        cmd_valid <= offer_item;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result against the oldest expectation and drives ready.
  // Once, after a number of results, ready is held low for a long stretch while the
  // sender keeps offering, so the block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result item with no item outstanding");
        end else begin
          want = expected_results.pop_front();
          if (valid_res !== want.ok) begin
            report_mismatch($sformatf("valid_res got %b want %b", valid_res, want.ok));
          end
          if (result_day_number !== want.dn) begin
            report_mismatch($sformatf("result_day_number got %0d want %0d",
                                      result_day_number, want.dn));
          end
          if (result_day !== want.d) begin
            report_mismatch($sformatf("result_day got %0d want %0d", result_day, want.d));
          end
          if (result_month !== want.m) begin
            report_mismatch($sformatf("result_month got %0d want %0d", result_month, want.m));
          end
          if (result_year !== want.y) begin
            report_mismatch($sformatf("result_year got %0d want %0d", result_year, want.y));
          end
          if (weekday !== want.wd) begin
            report_mismatch($sformatf("weekday got %0d want %0d", weekday, want.wd));
          end
        end
        results_seen++;
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else if (!long_stall_done && results_seen >= STALL_AT_RESULT) begin
        long_stall_done = 1'b1;
        stall_left      = LONG_STALL;
        res_ready       <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(99, 0) >= idle_percent(results_seen, 1'b1));
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    conv_item_t seed_item;
    // Range ends of the date direction, and the epoch itself, a Thursday.
    queue_date(1, MONTH_JAN, FIRST_YEAR);
    queue_date(31, MONTH_DEC, LAST_YEAR);
    // Leap rule: divisible by 400, plain century, ordinary leap and common year.
    queue_date(29, MONTH_FEB, 2000);
    queue_date(29, MONTH_FEB, 2100);
    queue_date(28, MONTH_FEB, 2100);
    queue_date(29, MONTH_FEB, 2024);
    queue_date(29, MONTH_FEB, 2023);
    // Day zero, the 31st of a long and of a short month.
    queue_date(0, MONTH_MAR, 1999);
    queue_date(31, MONTH_JAN, 2038);
    queue_date(31, MONTH_APR, 2038);
    // Month zero and months beyond December.
    queue_date(15, 0, 2001);
    queue_date(15, 13, 2001);
    // Years just outside the range and every field at its all-ones value.
    queue_date(31, MONTH_DEC, FIRST_YEAR - 1);
    queue_date(1, MONTH_JAN, LAST_YEAR + 1);
    queue_date(31, 15, 16383);
    // Shift direction: range ends, one step past each end, a day number above range,
    // offset extremes and full-span jumps both ways.
    queue_shift(0, 0);
    queue_shift(LAST_DAY_NUMBER, 0);
    queue_shift(0, -1);
    queue_shift(LAST_DAY_NUMBER, 1);
    queue_shift(LAST_DAY_NUMBER + 1, -1);
    queue_shift(4194303, -4194304);
    queue_shift(0, 4194303);
    queue_shift(0, LAST_DAY_NUMBER);
    queue_shift(LAST_DAY_NUMBER, -int'(LAST_DAY_NUMBER));
    queue_shift(11016, 1);

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      seed_item = random_item();
      // The sender pauses for a full drain before the random part and once in it.
      if (n == 0 || n == 380) begin
        seed_item.drain_first = 1'b1;
      end
      pending_items.push_back(seed_item);
    end
    total_items = pending_items.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || cmd_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Any stray result after the last expected one is still caught by the monitor.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d result items never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
